// ===== sv/tvc_pkg.sv =====
// Package for the terrain vertex color pipeline: payload structs, fixed-point
// constants (Q16, 1.0 = 65536) and the shared rounding and clamping helpers.
// No dependencies.
package tvc_pkg;

  typedef struct packed {
    logic signed [15:0] height_m;
    logic signed [15:0] normal_up;
    logic signed [15:0] noise_val;
  } vertex_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } color_t;

  typedef logic [15:0] chan_t;
  typedef chan_t [2:0] rgb_t;     // index 0 is red
  typedef logic [16:0] frac_t;    // 0 .. 1.0 inclusive in Q16

  localparam frac_t ONE  = 17'd65536;
  localparam frac_t HALF = 17'd32768;

  // Altitude and dryness coefficients.
  localparam logic signed [16:0] ALT_OFS    = 17'sd1024;
  localparam logic [18:0]        ALT_SCALE  = 19'd279620;
  localparam logic [11:0]        ALT_NOISE  = 12'd3932;
  localparam logic [14:0]        DRY_ALT    = 15'd26214;
  localparam logic [12:0]        ROCK_NOISE = 13'd6554;
  localparam logic [11:0]        SNOW_NOISE = 12'd3277;

  // Smoothstep lower edges and reciprocal widths.
  localparam frac_t       ROCK_E0    = 17'd22282;
  localparam logic [18:0] ROCK_RCP   = 19'd252062;
  localparam frac_t       SCREE_A_E0 = 17'd29491;
  localparam logic [18:0] SCREE_RCP  = 19'd218453;
  localparam frac_t       SCREE_S_E0 = 17'd11796;
  localparam frac_t       SNOW_A_E0  = 17'd48497;
  localparam logic [18:0] SNOW_A_RCP = 19'd297891;
  localparam frac_t       SNOW_S_E0  = 17'd27525;
  localparam logic [18:0] SNOW_S_RCP = 19'd273067;

  function automatic rgb_t mk_rgb(input chan_t r, input chan_t g, input chan_t b);
    rgb_t c;
    c[0] = r;
    c[1] = g;
    c[2] = b;
    return c;
  endfunction

  localparam rgb_t COL_GRASS  = mk_rgb(16'd10486, 16'd20972, 16'd5898);
  localparam rgb_t COL_MEADOW = mk_rgb(16'd22282, 16'd26214, 16'd10486);
  localparam rgb_t COL_DIRT   = mk_rgb(16'd22282, 16'd16384, 16'd9830);
  localparam rgb_t COL_ROCK   = mk_rgb(16'd22282, 16'd20316, 16'd18350);
  localparam rgb_t COL_SCREE  = mk_rgb(16'd36700, 16'd34734, 16'd32113);
  localparam rgb_t COL_SNOW   = mk_rgb(16'd60293, 16'd61604, 16'd64225);

  // Every blend stays between its two end colors, so all channels stay here.
  localparam chan_t CH_MIN = 16'd5898;
  localparam chan_t CH_MAX = 16'd64225;

  // Round to nearest, ties toward +infinity, then drop 16 fraction bits.
  function automatic logic signed [39:0] rnd16(input logic signed [39:0] v);
    return (v + 40'sd32768) >>> 16;
  endfunction

  function automatic frac_t sat01(input logic signed [39:0] v);
    frac_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > 40'sd65536) begin
      r = ONE;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/tvc_sstep.sv =====
// Four-stage smoothstep unit: scale, clamp and square, cubic product, round.
// The edge and reciprocal inputs are driven by constants from tvc_pkg.
module tvc_sstep (
  input  logic               clk_i,
  input  logic signed [18:0] x_i,
  input  tvc_pkg::frac_t     e0_i,
  input  logic [18:0]        recip_i,
  output tvc_pkg::frac_t     f_o
);
  import tvc_pkg::*;

  logic signed [19:0] diff;
  logic signed [39:0] p_d, p_q;
  frac_t              t_d, t_q;
  logic [33:0]        tt_d, tt_q;
  logic [33:0]        t2w;
  logic [17:0]        k;
  logic [34:0]        p2_d, p2_q;
  logic [34:0]        fw;
  frac_t              f_d, f_q;

  assign diff = 20'(x_i) - $signed({3'b000, e0_i});
  assign p_d  = diff * $signed({1'b0, recip_i});

  assign t_d  = sat01(rnd16(p_q));
  assign tt_d = t_d * t_d;

  assign t2w  = (tt_q + 34'd32768) >> 16;
  assign k    = 18'd196608 - {t_q, 1'b0};
  assign p2_d = t2w[16:0] * k;

  assign fw   = (p2_q + 35'd32768) >> 16;
  assign f_d  = fw[16:0];

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    t_q  <= t_d;
    tt_q <= tt_d;
    p2_q <= p2_d;
    f_q  <= f_d;
  end

  assign f_o = f_q;

endmodule

// ===== sv/tvc_blend.sv =====
// Two-stage RGB blend c + round((b - c) * t): product stage, then rounded sum.
// Uses rgb_t, frac_t and rnd16 from tvc_pkg.
module tvc_blend (
  input  logic           clk_i,
  input  tvc_pkg::rgb_t  c_i,
  input  tvc_pkg::rgb_t  b_i,
  input  tvc_pkg::frac_t t_i,
  output tvc_pkg::rgb_t  c_o
);
  import tvc_pkg::*;

  logic signed [35:0] p_d [3];
  logic signed [35:0] p_q [3];
  rgb_t               c_q;
  rgb_t               res_d, res_q;

  always_comb begin
    logic signed [17:0] diff;
    logic signed [39:0] r;
    for (int ch = 0; ch < 3; ch++) begin
      diff      = $signed({2'b00, b_i[ch]}) - $signed({2'b00, c_i[ch]});
      p_d[ch]   = diff * $signed({1'b0, t_i});
      r         = rnd16(40'(p_q[ch]));
      // The blended value is known to lie in 0..65535, so a 16-bit add suffices.
      res_d[ch] = c_q[ch] + r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    c_q   <= c_i;
    res_q <= res_d;
  end

  assign c_o = res_q;

endmodule

// ===== sv/terrain_vertex_color_top.sv =====
// Terrain vertex color pipeline; each start transfer returns its color with a done_o
// strobe. Throughput: one vertex per cycle; busy stays low and the
// receiver cannot stall, so every stage advances on every clock.
// The depth is set by the chain of four blends, each a multiply and a rounded add.
// Reset clears only the valid pipeline; no results appear until new transfers.
module terrain_vertex_color_top #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tvc_pkg::vertex_t vertex_i,
  output logic             done_o,
  output tvc_pkg::color_t  color_o
);
  import tvc_pkg::*;

  localparam int unsigned LAT     = 15;
  localparam logic [15:0] OUT_MAX = 16'((32'd1 << OUT_BITS) - 32'd1);

  logic [LAT-1:0] vld_d, vld_q;

  // Stage 1: widen inputs, constant products.
  logic signed [16:0] hh;
  logic signed [17:0] n;
  frac_t              nu;
  logic signed [36:0] s1_ph_d, s1_ph_q;
  logic signed [31:0] s1_pa_d, s1_pa_q, s1_pr_d, s1_pr_q, s1_ps_d, s1_ps_q;
  frac_t              s1_slope_d, s1_slope_q;
  logic signed [17:0] s1_dbase_d, s1_dbase_q;

  // Stage 2: altitude and noise offsets.
  frac_t              s2_alt_d, s2_alt_q;
  logic signed [18:0] s2_xr_d, s2_xr_q;
  logic signed [39:0] s2_snw;
  logic signed [15:0] s2_sn_d, s2_sn_q;
  frac_t              s2_slope_q;
  logic signed [17:0] s2_dbase_q;

  // Stage 3: smoothstep arguments and dryness product.
  logic signed [18:0] s3_xs_d, s3_xs_q;
  logic [31:0]        s3_pd_d, s3_pd_q;
  frac_t              s3_alt_q, s3_slope_q;
  logic signed [18:0] s3_xr_q;
  logic signed [17:0] s3_dbase_q;

  // Stage 4: dryness.
  frac_t s4_dry_d, s4_dry_q;
  frac_t dm;
  rgb_t  base_c, base_b;
  frac_t base_t;

  // Smoothstep outputs, valid at stage 7.
  frac_t ss_rock, ss_sa, ss_ss, ss_wa, ss_ws;

  rgb_t  c1, s7_c1_q, c2, c3, c4;

  logic [33:0] s8_pscree_d, s8_pscree_q, s8_psnow_d, s8_psnow_q;
  frac_t       s9_scree_d, s9_scree_q, s9_snow_d, s9_snow_q;
  frac_t       s10_snow_q, s11_snow_q;

  logic [31:0] s14_p_d [3];
  logic [31:0] s14_p_q [3];
  rgb_t        out_d, out_q;

  assign busy  = 1'b0;
  assign vld_d = {vld_q[LAT-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    hh = 17'(vertex_i.height_m) + ALT_OFS;
    n  = $signed({vertex_i.noise_val[15], vertex_i.noise_val, 1'b0});
    // A negative normal counts as vertical ground.
    if (vertex_i.normal_up[15]) begin
      nu = '0;
    end else begin
      nu = {1'b0, vertex_i.normal_up[14:0], 1'b0};
    end
    s1_slope_d = ONE - nu;
    s1_ph_d    = hh * $signed({1'b0, ALT_SCALE});
    s1_pa_d    = n * $signed({1'b0, ALT_NOISE});
    s1_pr_d    = n * $signed({1'b0, ROCK_NOISE});
    s1_ps_d    = n * $signed({1'b0, SNOW_NOISE});
    // Rounding 0.5 * n in Q16 gives the raw noise sample back exactly.
    s1_dbase_d = 18'sd32768 + 18'(vertex_i.noise_val);
  end

  always_comb begin
    s2_alt_d = sat01(rnd16(40'(s1_ph_q)) + rnd16(40'(s1_pa_q)));
    s2_xr_d  = $signed({2'b00, s1_slope_q}) + 19'(rnd16(40'(s1_pr_q)));
    s2_snw   = rnd16(40'(s1_ps_q));
    s2_sn_d  = s2_snw[15:0];
  end

  assign s3_xs_d = $signed({2'b00, s2_alt_q}) + 19'(s2_sn_q);
  assign s3_pd_d = s2_alt_q * DRY_ALT;

  assign s4_dry_d = sat01(40'(s3_dbase_q) + rnd16($signed({8'b0, s3_pd_q})));

  // Dry ground below one half blends grass to meadow, otherwise meadow to dirt.
  always_comb begin
    dm = s4_dry_q - HALF;
    if (s4_dry_q < HALF) begin
      base_c = COL_GRASS;
      base_b = COL_MEADOW;
      base_t = {s4_dry_q[15:0], 1'b0};
    end else begin
      base_c = COL_MEADOW;
      base_b = COL_DIRT;
      base_t = {dm[15:0], 1'b0};
    end
  end

  tvc_sstep u_ss_rock (
    .clk_i(clk_i), .x_i(s3_xr_q), .e0_i(ROCK_E0), .recip_i(ROCK_RCP), .f_o(ss_rock)
  );
  tvc_sstep u_ss_scree_alt (
    .clk_i(clk_i), .x_i($signed({2'b00, s3_alt_q})), .e0_i(SCREE_A_E0),
    .recip_i(SCREE_RCP), .f_o(ss_sa)
  );
  tvc_sstep u_ss_scree_slope (
    .clk_i(clk_i), .x_i($signed({2'b00, s3_slope_q})), .e0_i(SCREE_S_E0),
    .recip_i(SCREE_RCP), .f_o(ss_ss)
  );
  tvc_sstep u_ss_snow_alt (
    .clk_i(clk_i), .x_i(s3_xs_q), .e0_i(SNOW_A_E0), .recip_i(SNOW_A_RCP), .f_o(ss_wa)
  );
  tvc_sstep u_ss_snow_slope (
    .clk_i(clk_i), .x_i($signed({2'b00, s3_slope_q})), .e0_i(SNOW_S_E0),
    .recip_i(SNOW_S_RCP), .f_o(ss_ws)
  );

  tvc_blend u_bl_base (
    .clk_i(clk_i), .c_i(base_c), .b_i(base_b), .t_i(base_t), .c_o(c1)
  );
  tvc_blend u_bl_rock (
    .clk_i(clk_i), .c_i(s7_c1_q), .b_i(COL_ROCK), .t_i(ss_rock), .c_o(c2)
  );
  tvc_blend u_bl_scree (
    .clk_i(clk_i), .c_i(c2), .b_i(COL_SCREE), .t_i(s9_scree_q), .c_o(c3)
  );
  tvc_blend u_bl_snow (
    .clk_i(clk_i), .c_i(c3), .b_i(COL_SNOW), .t_i(s11_snow_q), .c_o(c4)
  );

  assign s8_pscree_d = ss_sa * ss_ss;
  assign s8_psnow_d  = ss_wa * (ONE - ss_ws);
  assign s9_scree_d  = sat01(rnd16($signed({6'b0, s8_pscree_q})));
  assign s9_snow_d   = sat01(rnd16($signed({6'b0, s8_psnow_q})));

  always_comb begin
    logic [31:0] rw;
    for (int ch = 0; ch < 3; ch++) begin
      s14_p_d[ch] = c4[ch] * OUT_MAX;
      rw          = (s14_p_q[ch] + 32'd32768) >> 16;
      out_d[ch]   = rw[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ph_q     <= s1_ph_d;
    s1_pa_q     <= s1_pa_d;
    s1_pr_q     <= s1_pr_d;
    s1_ps_q     <= s1_ps_d;
    s1_slope_q  <= s1_slope_d;
    s1_dbase_q  <= s1_dbase_d;
    s2_alt_q    <= s2_alt_d;
    s2_xr_q     <= s2_xr_d;
    s2_sn_q     <= s2_sn_d;
    s2_slope_q  <= s1_slope_q;
    s2_dbase_q  <= s1_dbase_q;
    s3_xs_q     <= s3_xs_d;
    s3_pd_q     <= s3_pd_d;
    s3_alt_q    <= s2_alt_q;
    s3_slope_q  <= s2_slope_q;
    s3_xr_q     <= s2_xr_q;
    s3_dbase_q  <= s2_dbase_q;
    s4_dry_q    <= s4_dry_d;
    s7_c1_q     <= c1;
    s8_pscree_q <= s8_pscree_d;
    s8_psnow_q  <= s8_psnow_d;
    s9_scree_q  <= s9_scree_d;
    s9_snow_q   <= s9_snow_d;
    s10_snow_q  <= s9_snow_q;
    s11_snow_q  <= s10_snow_q;
    s14_p_q     <= s14_p_d;
    out_q       <= out_d;
  end

  assign done_o        = vld_q[LAT-1];
  assign color_o.red   = out_q[0];
  assign color_o.green = out_q[1];
  assign color_o.blue  = out_q[2];

  // A strobe must trace back to a start transfer exactly one latency earlier.
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("done_o without a start transfer one latency earlier");

  // After all blends the color lies inside the hull of the palette.
  a_color_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[12] |-> (c4[0] >= CH_MIN && c4[0] <= CH_MAX &&
                   c4[1] >= CH_MIN && c4[1] <= CH_MAX &&
                   c4[2] >= CH_MIN && c4[2] <= CH_MAX))
    else $error("blended color left the palette range");

  // Scaled outputs never exceed the full-scale code for OUT_BITS.
  a_out_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (color_o.red <= OUT_MAX && color_o.green <= OUT_MAX &&
                color_o.blue <= OUT_MAX))
    else $error("output channel above full scale");

endmodule

// ===== verif/terrain_vertex_color_top_tb.sv =====
// Self-checking testbench for terrain_vertex_color_top: directed and random vertices
// against a fixed-point color predictor kept in a small scoreboard class.
// Depends on tvc_pkg for the vertex and color payload types.
module terrain_vertex_color_top_tb;

  localparam int unsigned OUT_BITS  = 16;
  localparam longint      CHAN_MAX  = (64'sd1 << OUT_BITS) - 1;
  localparam longint      UNIT      = 65536;
  localparam int          LATENCY   = 15;
  localparam int          PHASE_LEN = 245;

  // Palette, one 16-bit Q16 fraction per channel, red in slot 0.
  localparam logic [2:0][15:0] GRASS  = {16'd5898,  16'd20972, 16'd10486};
  localparam logic [2:0][15:0] MEADOW = {16'd10486, 16'd26214, 16'd22282};
  localparam logic [2:0][15:0] DIRT   = {16'd9830,  16'd16384, 16'd22282};
  localparam logic [2:0][15:0] ROCK   = {16'd18350, 16'd20316, 16'd22282};
  localparam logic [2:0][15:0] SCREE  = {16'd32113, 16'd34734, 16'd36700};
  localparam logic [2:0][15:0] SNOW   = {16'd64225, 16'd61604, 16'd60293};

  // Edges and reciprocal widths of the five smoothstep ramps.
  localparam longint ROCK_EDGE    = 22282;
  localparam longint ROCK_RECIP   = 252062;
  localparam longint SCREE_A_EDGE = 29491;
  localparam longint SCREE_S_EDGE = 11796;
  localparam longint SCREE_RECIP  = 218453;
  localparam longint SNOW_A_EDGE  = 48497;
  localparam longint SNOW_A_RECIP = 297891;
  localparam longint SNOW_S_EDGE  = 27525;
  localparam longint SNOW_S_RECIP = 273067;

  class color_ledger;
    tvc_pkg::color_t pending_colors[$];
    int unsigned     checked    = 0;
    int unsigned     mismatches = 0;
    int unsigned     strays     = 0;

    // Drop 16 fraction bits, rounding to nearest with ties toward +infinity.
    function longint q16(longint v);
      return (v + 64'sd32768) >>> 16;
    endfunction

    function longint unit_clamp(longint v);
      return (v < 0) ? 64'sd0 : ((v > UNIT) ? UNIT : v);
    endfunction

    function longint ease(longint edge0, longint recip, longint x);
      longint t, t2;
      t  = unit_clamp(q16((x - edge0) * recip));
      t2 = q16(t * t);
      return q16(t2 * (3 * UNIT - 2 * t));
    endfunction

    function longint mix(longint a, longint b, longint t);
      return a + q16((b - a) * t);
    endfunction

    function tvc_pkg::color_t shade_vertex(tvc_pkg::vertex_t v);
      longint h, up, n, slope, alt, dry, rock_f, scree_f, snow_f;
      longint c [3];
      logic [2:0][15:0] chan;
      tvc_pkg::color_t res;
      h     = longint'($signed(v.height_m));
      up    = unit_clamp(longint'($signed(v.normal_up)) * 2);
      n     = longint'($signed(v.noise_val)) * 2;
      slope = UNIT - up;
      alt   = unit_clamp(q16((h + 1024) * 279620) + q16(3932 * n));
      dry   = unit_clamp(32768 + q16(32768 * n) + q16(26214 * alt));
      rock_f  = ease(ROCK_EDGE, ROCK_RECIP, slope + q16(6554 * n));
      scree_f = unit_clamp(q16(ease(SCREE_A_EDGE, SCREE_RECIP, alt) *
                               ease(SCREE_S_EDGE, SCREE_RECIP, slope)));
      snow_f  = q16(ease(SNOW_A_EDGE, SNOW_A_RECIP, alt + q16(3277 * n)) *
                    (UNIT - ease(SNOW_S_EDGE, SNOW_S_RECIP, slope)));
      for (int i = 0; i < 3; i++) begin
        // Dryness of exactly one half takes the meadow-to-dirt side.
        if (dry < 32768) begin
          c[i] = mix(longint'(GRASS[i]), longint'(MEADOW[i]), dry * 2);
        end else begin
          c[i] = mix(longint'(MEADOW[i]), longint'(DIRT[i]), (dry - 32768) * 2);
        end
        c[i] = mix(c[i], longint'(ROCK[i]), rock_f);
        c[i] = mix(c[i], longint'(SCREE[i]), scree_f);
        c[i] = mix(c[i], longint'(SNOW[i]), snow_f);
        chan[i] = 16'(q16(unit_clamp(c[i]) * CHAN_MAX));
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
    endfunction

    function void note_vertex(tvc_pkg::vertex_t v);
      pending_colors.insert(pending_colors.size(), shade_vertex(v));
    endfunction

    function void check_color(tvc_pkg::color_t got);
      tvc_pkg::color_t want;
      if (pending_colors.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) begin
          $display("unexpected color %h/%h/%h with nothing pending",
                   got.red, got.green, got.blue);
        end
        return;
      end
      want = pending_colors.pop_front();
      checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches + strays <= 10) begin
          $display("color %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h", checked,
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  tvc_pkg::vertex_t vertex_i;
  logic             done_o;
  tvc_pkg::color_t  color_o;

  color_ledger ledger;
  int unsigned vertices_sent = 0;
  int unsigned idle_cycles   = 0;

  terrain_vertex_color_top #(
    .OUT_BITS(OUT_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .vertex_i(vertex_i),
    .done_o  (done_o),
    .color_o (color_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      ledger.check_color(color_o);
    end
  end

  // Holds start high until the block takes the vertex.
  task automatic send_vertex(input tvc_pkg::vertex_t v);
    start    <= 1'b1;
    vertex_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ledger.note_vertex(v);
    vertices_sent++;
  endtask

  task automatic send_fields(input int h, input int up, input int n);
    tvc_pkg::vertex_t v;
    v.height_m  = h[15:0];
    v.normal_up = up[15:0];
    v.noise_val = n[15:0];
    send_vertex(v);
  endtask

  // Each cycle is left idle with the given chance, so about pct percent of cycles idle.
  task automatic maybe_idle(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      idle_cycles++;
    end
  endtask

  // Stops sending until every pending color has come back.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (ledger.pending_colors.size() != 0);
  endtask

  // Mostly plausible terrain, plus full-range noise and dryness-border cases.
  function automatic tvc_pkg::vertex_t pick_vertex();
    tvc_pkg::vertex_t v;
    int h, up, n;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        h  = int'($urandom_range(17000)) - 1536;
        up = ($urandom_range(7) == 0) ? -int'($urandom_range(32768))
                                      : int'($urandom_range(32767));
        n  = int'($urandom_range(26000)) - 13000;
      end
      6, 7: begin
        h  = int'($urandom);
        up = int'($urandom);
        n  = int'($urandom);
      end
      8: begin
        h  = int'($urandom_range(65535));
        up = int'($urandom_range(32767));
        n  = $urandom_range(1) ? int'($urandom_range(32767, 28000))
                               : -int'($urandom_range(32768, 28000));
      end
      default: begin
        h  = int'($urandom_range(400)) - 1200;
        up = int'($urandom_range(32767));
        n  = int'($urandom_range(200)) - 100;
      end
    endcase
    v.height_m  = h[15:0];
    v.normal_up = up[15:0];
    v.noise_val = n[15:0];
    return v;
  endfunction

  int unsigned idle_pct [3] = '{0, 54, 27};

  initial begin
    clk_i    = 1'b0;
    rst_ni   = 1'b0;
    start    = 1'b0;
    vertex_i = '0;
    ledger   = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(0, 0, 0);
    send_fields(32767, 32767, 32767);
    send_fields(-32768, -32768, -32768);
    send_fields(32767, 0, -32768);
    send_fields(-32768, 32767, 32767);
    send_fields(2000, -16384, 0);         // negative normal counts as vertical
    send_fields(2000, 0, 0);
    send_fields(2000, 32767, 0);
    send_fields(-1024, 20000, 0);         // dryness lands exactly on one half
    send_fields(-1024, 20000, -1);        // dryness just below one half
    send_fields(15360, 32767, 0);         // high and flat: snow
    send_fields(15360, 32767, 32767);
    send_fields(10000, 8000, 0);          // high and steep: scree
    send_fields(0, 10000, 0);             // low and steep: rock
    send_fields(3000, 20000, 32767);
    send_fields(3000, 20000, -32768);
    send_fields(-1536, 32767, -32768);
    send_fields('h5555, 'h5555, 'h5555);
    send_fields('hAAAA, 'hAAAA, 'hAAAA);
    send_fields('h7FFF, 1, 'h0001);
    send_fields('h8001, 'hFFFF, 'hFFFE);
    drain();

    for (int p = 0; p < 3; p++) begin
      for (int k = 0; k < PHASE_LEN; k++) begin
        send_vertex(pick_vertex());
        maybe_idle(idle_pct[p]);
      end
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Shaded %0d vertices with %0d sender idle cycles; %0d colors checked.",
             vertices_sent, idle_cycles, ledger.checked);
    $display("Mismatches %0d, unexpected colors %0d, still pending %0d.",
             ledger.mismatches, ledger.strays, ledger.pending_colors.size());
    if (ledger.mismatches == 0 && ledger.strays == 0 &&
        ledger.pending_colors.size() == 0) begin
      $display("terrain_vertex_color_top_tb: clean");
    end else begin
      $display("terrain_vertex_color_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d colors still pending.", ledger.pending_colors.size());
    $display("terrain_vertex_color_top_tb: errors");
    $finish;
  end

endmodule
